// File: design/rpi_pkg.sv
// Package for the radial profile interpolator: sizes, codes and word types.
// Depends on nothing; the top level, the checker and the bench import it.
package rpi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // pi/2 in Q1.30, used to turn the trapezoid sum into the integral.
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;

    // Divider steps: one quotient bit per cycle over a 64-bit dividend.
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] TARGET_POWER_RESET = 32'h0001_0000;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NO_TABLE = 2'd3;

    typedef struct packed {
        logic        func;
        logic [23:0] radius;
        logic [31:0] density;
        logic        final_entry;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_result;

endpackage

// File: design/rpi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module rpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/radial_profile_interpolator.sv
// Radial profile interpolator top level: sequencer, shared multiplier and divider.
// Depends on rpi_pkg and rpi_ram (radius and density tables).
// A load word stores its entry and adds its trapezoid term; the closing word of a valid
// load adds a normalisation pass that reads, scales, divides and writes back each entry;
// a query runs s binary search steps (s at most 9), each a table read, then interpolates.
// The bit-serial 64-step divider and the one-read-per-cycle table RAMs set the run time.
// One word at a time: busy is high from acceptance until the result strobe.
// Synchronous active-low reset clears the table state; the receiver cannot stall.
module radial_profile_interpolator
    import rpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_res_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LD0  = 5'd1;
    localparam logic [4:0] S_LD1  = 5'd2;
    localparam logic [4:0] S_LD2  = 5'd3;
    localparam logic [4:0] S_LD3  = 5'd4;
    localparam logic [4:0] S_LD4  = 5'd5;
    localparam logic [4:0] S_LD5  = 5'd6;
    localparam logic [4:0] S_NI0  = 5'd7;
    localparam logic [4:0] S_NI1  = 5'd8;
    localparam logic [4:0] S_NI2  = 5'd9;
    localparam logic [4:0] S_NI3  = 5'd10;
    localparam logic [4:0] S_NI4  = 5'd11;
    localparam logic [4:0] S_NRD  = 5'd12;
    localparam logic [4:0] S_NMA  = 5'd13;
    localparam logic [4:0] S_NMB  = 5'd14;
    localparam logic [4:0] S_NWB  = 5'd15;
    localparam logic [4:0] S_DIV  = 5'd16;
    localparam logic [4:0] S_Q0   = 5'd17;
    localparam logic [4:0] S_QCHK = 5'd18;
    localparam logic [4:0] S_QCMP = 5'd19;
    localparam logic [4:0] S_QEND = 5'd20;
    localparam logic [4:0] S_QR0  = 5'd21;
    localparam logic [4:0] S_QR1  = 5'd22;
    localparam logic [4:0] S_QM0  = 5'd23;
    localparam logic [4:0] S_QM1  = 5'd24;
    localparam logic [4:0] S_QM2  = 5'd25;

    // Control state.
    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready, n_ready;
    logic             r_loading, n_loading;
    logic             r_ovf, n_ovf;
    logic             r_strobe, n_strobe;
    logic [31:0]      r_tp, n_tp;

    // Working registers.
    logic             r_mono, n_mono;
    t_item            r_item, n_item;
    t_result          r_res, n_res;
    logic [23:0]      r_prev_r, n_prev_r;
    logic [31:0]      r_prev_d, n_prev_d;
    logic [47:0]      r_prev_sq, n_prev_sq;
    logic [32:0]      r_a, n_a;
    logic [47:0]      r_b, n_b;
    logic             r_pair, n_pair;
    logic             r_wr, n_wr;
    logic [88:0]      r_sum, n_sum;
    logic [95:0]      r_acc, n_acc;
    logic [64:0]      r_prod, n_prod;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [23:0]      r_r0, n_r0;
    logic [31:0]      r_d0, n_d0;
    logic [31:0]      r_d1, n_d1;
    logic [23:0]      r_dd, n_dd;
    logic [23:0]      r_nn, n_nn;
    logic [63:0]      r_q, n_q;
    logic [57:0]      r_rem, n_rem;
    logic [57:0]      r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ret_query, n_ret_query;

    // Multiplier operands and RAM ports.
    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic              rad_we, den_we;
    logic [ADDR_W-1:0] rad_waddr, den_waddr, raddr;
    logic [31:0]       den_wdata;
    logic [23:0]       rad_rdata;
    logic [31:0]       den_rdata;

    rpi_ram #(.WIDTH(24), .DEPTH(TABLE_DEPTH)) u_rad_ram (
        .i_clk   (i_clk),
        .i_we    (rad_we),
        .i_waddr (rad_waddr),
        .i_wdata (r_item.radius),
        .i_raddr (raddr),
        .o_rdata (rad_rdata)
    );

    rpi_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_den_ram (
        .i_clk   (i_clk),
        .i_we    (den_we),
        .i_waddr (den_waddr),
        .i_wdata (den_wdata),
        .i_raddr (raddr),
        .o_rdata (den_rdata)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_result     = r_res;

    always_comb begin
        logic [CNT_W-1:0] c;
        logic             ovf_in;
        logic [58:0]      rem_sh;
        logic             ge;
        logic [CNT_W:0]   mid_sum;
        logic [CNT_W-1:0] lo_m1;
        logic [CNT_W-1:0] idx_p1;
        logic [57:0]      i_val;
        logic             rnd;
        logic [64:0]      q_r;
        logic [31:0]      q_sat;

        n_state = r_state;  n_count = r_count;  n_ready = r_ready;
        n_loading = r_loading;  n_ovf = r_ovf;  n_strobe = 1'b0;  n_tp = r_tp;
        n_mono = r_mono;  n_item = r_item;  n_res = r_res;
        n_prev_r = r_prev_r;  n_prev_d = r_prev_d;  n_prev_sq = r_prev_sq;
        n_a = r_a;  n_b = r_b;  n_pair = r_pair;  n_wr = r_wr;
        n_sum = r_sum;  n_acc = r_acc;  n_idx = r_idx;
        n_lo = r_lo;  n_hi = r_hi;  n_r0 = r_r0;  n_d0 = r_d0;  n_d1 = r_d1;
        n_dd = r_dd;  n_nn = r_nn;  n_q = r_q;  n_rem = r_rem;  n_div = r_div;
        n_cnt = r_cnt;  n_ret_query = r_ret_query;

        mul_a = '0;  mul_b = '0;
        rad_we = 1'b0;  den_we = 1'b0;
        rad_waddr = '0;  den_waddr = '0;  den_wdata = r_item.density;
        raddr = '0;

        c       = r_loading ? r_count : '0;
        ovf_in  = r_loading & r_ovf;
        rem_sh  = {r_rem, r_q[63]};
        ge      = (rem_sh >= {1'b0, r_div});
        mid_sum = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;
        lo_m1   = r_lo - CNT_W'(1);
        idx_p1  = r_idx + CNT_W'(1);
        i_val   = r_acc[95:38];
        rnd     = ({r_rem, 1'b0} >= {1'b0, r_div});
        q_r     = {1'b0, r_q} + 65'(rnd);
        q_sat   = (q_r[64:32] != '0) ? 32'hFFFF_FFFF : q_r[31:0];

        if (i_cfg_valid) begin
            n_tp = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = (i_item.func == FUNC_QUERY) ? S_Q0 : S_LD0;
                end
            end

            // Store the entry, track ordering, start squaring the radius.
            S_LD0: begin
                mul_a     = {9'd0, r_item.radius};
                mul_b     = {8'd0, r_item.radius};
                n_loading = 1'b1;
                n_ovf     = ovf_in;
                if (!r_loading) begin
                    n_ready = 1'b0;
                    n_sum   = '0;
                end
                if (c < CNT_W'(TABLE_DEPTH)) begin
                    rad_we    = 1'b1;
                    den_we    = 1'b1;
                    rad_waddr = c[ADDR_W-1:0];
                    den_waddr = c[ADDR_W-1:0];
                    n_count   = c + CNT_W'(1);
                    n_wr      = 1'b1;
                    n_pair    = (c != '0);
                    n_mono    = (c == '0) ? (r_item.radius == '0)
                                          : (r_mono && (r_item.radius > r_prev_r));
                    n_prev_r  = r_item.radius;
                    n_prev_d  = r_item.density;
                    n_a       = {1'b0, r_prev_d} + {1'b0, r_item.density};
                end else begin
                    n_count = c;
                    n_ovf   = 1'b1;
                    n_wr    = 1'b0;
                    n_pair  = 1'b0;
                end
                n_state = S_LD1;
            end

            S_LD1: begin
                if (r_wr) begin
                    n_b       = r_prod[47:0] - r_prev_sq;
                    n_prev_sq = r_prod[47:0];
                end
                n_state = S_LD2;
            end

            S_LD2: begin
                mul_a   = r_a;
                mul_b   = {8'd0, r_b[23:0]};
                n_state = S_LD3;
            end

            S_LD3: begin
                mul_a = r_a;
                mul_b = {8'd0, r_b[47:24]};
                if (r_pair) begin
                    n_sum = r_sum + {24'd0, r_prod};
                end
                n_state = S_LD4;
            end

            S_LD4: begin
                if (r_pair) begin
                    n_sum = r_sum + {r_prod, 24'd0};
                end
                n_state = S_LD5;
            end

            S_LD5: begin
                n_res.value  = '0;
                n_res.status = r_ovf ? ST_OVERFLOW : ST_OK;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
                if (r_item.final_entry) begin
                    n_loading = 1'b0;
                    if (!r_ovf) begin
                        if (!((r_count >= CNT_W'(2)) && r_mono)) begin
                            n_res.status = ST_INVALID;
                        end else if (r_sum == '0) begin
                            n_ready = 1'b1;
                        end else begin
                            n_strobe = 1'b0;
                            n_state  = S_NI0;
                        end
                    end
                end
            end

            // Integral = floor(floor(S / 2^24) * HALF_PI_Q30 / 2^38), in three slices.
            S_NI0: begin
                mul_a   = {9'd0, r_sum[47:24]};
                mul_b   = {1'b0, HALF_PI_Q30};
                n_state = S_NI1;
            end

            S_NI1: begin
                mul_a   = {9'd0, r_sum[71:48]};
                mul_b   = {1'b0, HALF_PI_Q30};
                n_acc   = {31'd0, r_prod};
                n_state = S_NI2;
            end

            S_NI2: begin
                mul_a   = {16'd0, r_sum[88:72]};
                mul_b   = {1'b0, HALF_PI_Q30};
                n_acc   = r_acc + {7'd0, r_prod, 24'd0};
                n_state = S_NI3;
            end

            S_NI3: begin
                n_acc   = r_acc + {r_prod[47:0], 48'd0};
                n_state = S_NI4;
            end

            S_NI4: begin
                n_div   = (i_val == '0) ? 58'd1 : i_val;
                n_idx   = '0;
                n_state = S_NRD;
            end

            S_NRD: begin
                raddr   = r_idx[ADDR_W-1:0];
                n_state = S_NMA;
            end

            S_NMA: begin
                mul_a   = {1'b0, den_rdata};
                mul_b   = r_tp;
                n_state = S_NMB;
            end

            S_NMB: begin
                n_q         = r_prod[63:0];
                n_rem       = '0;
                n_cnt       = '0;
                n_ret_query = 1'b0;
                n_state     = S_DIV;
            end

            // Restoring division, one quotient bit per cycle.
            S_DIV: begin
                n_rem = ge ? 58'(rem_sh - {1'b0, r_div}) : rem_sh[57:0];
                n_q   = {r_q[62:0], ge};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    if (r_ret_query) begin
                        n_res.value  = n_q[31:0];
                        n_res.status = ST_OK;
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_NWB;
                    end
                end
            end

            S_NWB: begin
                den_we    = 1'b1;
                den_waddr = r_idx[ADDR_W-1:0];
                den_wdata = q_sat;
                n_idx     = idx_p1;
                if (idx_p1 == r_count) begin
                    n_ready      = 1'b1;
                    n_res.value  = '0;
                    n_res.status = ST_OK;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_NRD;
                end
            end

            S_Q0: begin
                n_lo = '0;
                n_hi = r_count;
                if (!r_ready) begin
                    n_res.value  = '0;
                    n_res.status = ST_NO_TABLE;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_item.radius == '0) begin
                    n_res.value  = '0;
                    n_res.status = ST_OK;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_QCHK;
                end
            end

            // Lower-bound search: first entry whose radius is not below the query.
            S_QCHK: begin
                raddr = mid_sum[ADDR_W-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_QCMP;
                end else begin
                    n_state = S_QEND;
                end
            end

            S_QCMP: begin
                if (rad_rdata < r_item.radius) begin
                    n_lo = CNT_W'(mid_sum) + CNT_W'(1);
                end else begin
                    n_hi = CNT_W'(mid_sum);
                end
                n_state = S_QCHK;
            end

            S_QEND: begin
                raddr = lo_m1[ADDR_W-1:0];
                if ((r_lo == '0) || (r_lo >= r_count)) begin
                    n_res.value  = '0;
                    n_res.status = ST_OK;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_QR0;
                end
            end

            S_QR0: begin
                raddr   = r_lo[ADDR_W-1:0];
                n_r0    = rad_rdata;
                n_d0    = den_rdata;
                n_state = S_QR1;
            end

            S_QR1: begin
                n_dd    = rad_rdata - r_r0;
                n_nn    = r_item.radius - r_r0;
                n_d1    = den_rdata;
                n_state = S_QM0;
            end

            S_QM0: begin
                mul_a   = {1'b0, r_d0};
                mul_b   = {8'd0, r_dd - r_nn};
                n_state = S_QM1;
            end

            S_QM1: begin
                mul_a   = {1'b0, r_d1};
                mul_b   = {8'd0, r_nn};
                n_q     = r_prod[63:0];
                n_state = S_QM2;
            end

            S_QM2: begin
                n_q         = r_q + r_prod[63:0] + {41'd0, r_dd[23:1]};
                n_div       = {34'd0, r_dd};
                n_rem       = '0;
                n_cnt       = '0;
                n_ret_query = 1'b1;
                n_state     = S_DIV;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_prod = {32'd0, mul_a} * {33'd0, mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ready   <= 1'b0;
            r_loading <= 1'b0;
            r_ovf     <= 1'b0;
            r_strobe  <= 1'b0;
            r_tp      <= TARGET_POWER_RESET;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ready   <= n_ready;
            r_loading <= n_loading;
            r_ovf     <= n_ovf;
            r_strobe  <= n_strobe;
            r_tp      <= n_tp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mono      <= n_mono;
        r_item      <= n_item;
        r_res       <= n_res;
        r_prev_r    <= n_prev_r;
        r_prev_d    <= n_prev_d;
        r_prev_sq   <= n_prev_sq;
        r_a         <= n_a;
        r_b         <= n_b;
        r_pair      <= n_pair;
        r_wr        <= n_wr;
        r_sum       <= n_sum;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_r0        <= n_r0;
        r_d0        <= n_d0;
        r_d1        <= n_d1;
        r_dd        <= n_dd;
        r_nn        <= n_nn;
        r_q         <= n_q;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_cnt       <= n_cnt;
        r_ret_query <= n_ret_query;
    end

endmodule

// File: design/rpi_checker.sv
// Port-level checker for the radial profile interpolator, with its bind.
// Depends on rpi_pkg and the top level's port list.
module rpi_checker
    import rpi_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_strobe,
    input t_result     o_result
);

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // The block goes idle only by delivering the word's result.
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_res_strobe)
        else $error("block went idle without a result");

    // A result appears only once work has finished.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result strobed while still busy");

    // Results never come in consecutive cycles.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("two results for one word");

    // Without a table the value is zero.
    a_no_table_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_result.status == ST_NO_TABLE)) |-> (o_result.value == '0))
        else $error("non-zero value without a table");

endmodule

bind radial_profile_interpolator rpi_checker u_rpi_checker (.*);

// File: bench/radial_profile_interpolator_tb.sv
// Self-checking bench for the radial profile interpolator: table loads, normalisation, queries.
// Depends on rpi_pkg and the design files; it has its own model of the expected results.
module radial_profile_interpolator_tb;
    import rpi_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_res_strobe;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    radial_profile_interpolator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_strobe(o_res_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // The clock toggles every five time units, giving a period of ten.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The bench's own copy of the block's state and its one register.
    logic [23:0] prof_radius [TABLE_DEPTH];
    logic [31:0] prof_density [TABLE_DEPTH];
    int unsigned prof_count;
    bit          prof_ready;
    bit          prof_loading;
    bit          prof_overflow;
    logic [31:0] power_setting;

    // Words waiting to be sent, and the results that the model says must come back.
    t_item   word_queue [$];
    t_result result_queue [$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned words_sent;
    int unsigned queries_sent;
    int unsigned power_writes;
    bit          quiet_mode;
    bit          hold_sender;

    // Appends one word to the end of the pending queue.
    function automatic void queue_word(t_item w);
        word_queue.insert(word_queue.size(), w);
    endfunction

    // True when the loaded table may be normalised: two or more entries, radius zero
    // first and radii that rise strictly.
    function automatic bit profile_is_valid();
        if (prof_count < 2 || prof_radius[0] != 24'd0) return 1'b0;
        for (int unsigned k = 1; k < prof_count; k++)
            if (prof_radius[k] <= prof_radius[k-1]) return 1'b0;
        return 1'b1;
    endfunction

    // Scales every density so that the trapezoid integral of 2*pi*r*density matches the
    // power setting. The sum is kept exactly in 128 bits, which holds it comfortably.
    task automatic normalise_profile();
        logic [127:0] area_sum;
        logic [63:0]  sum_hi;
        logic [63:0]  integral;
        logic [63:0]  prod, quot, remn;
        logic [47:0]  sq_step;
        logic [32:0]  pair;
        area_sum = '0;
        for (int unsigned k = 0; k + 1 < prof_count; k++) begin
            pair     = {1'b0, prof_density[k]} + {1'b0, prof_density[k+1]};
            sq_step  = 48'(prof_radius[k+1]) * 48'(prof_radius[k+1])
                     - 48'(prof_radius[k]) * 48'(prof_radius[k]);
            area_sum = area_sum + 128'(pair) * 128'(sq_step);
        end
        if (area_sum == '0) return;
        sum_hi   = 64'(area_sum >> 24);
        integral = ((sum_hi >> 32) * 64'h6487ED51
                   + (((sum_hi & 64'hFFFF_FFFF) * 64'h6487ED51) >> 32)) >> 6;
        if (integral == 0) integral = 64'd1;
        for (int unsigned k = 0; k < prof_count; k++) begin
            prod = 64'(prof_density[k]) * 64'(power_setting);
            quot = prod / integral;
            remn = prod % integral;
            if (remn >= integral - remn) quot++;
            prof_density[k] = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        end
    endtask

    // Linear interpolation between the two entries that bracket the radius.
    function automatic logic [31:0] interpolate_density(logic [23:0] r);
        int unsigned lo, hi, mid;
        logic [63:0] span, off, num;
        if (r == 24'd0) return 32'd0;
        lo = 0;
        hi = prof_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (prof_radius[mid] < r) lo = mid + 1;
            else hi = mid;
        end
        if (lo == 0 || lo >= prof_count) return 32'd0;
        span = 64'(prof_radius[lo]) - 64'(prof_radius[lo-1]);
        off  = 64'(r) - 64'(prof_radius[lo-1]);
        num  = 64'(prof_density[lo-1]) * (span - off) + 64'(prof_density[lo]) * off;
        return 32'((num + span / 2) / span);
    endfunction

    // Works out the one result a word causes and updates the model state.
    task automatic predict_profile_word(t_item w);
        t_result res;
        res = '0;
        if (w.func == FUNC_QUERY) begin
            if (!prof_ready) res.status = ST_NO_TABLE;
            else res.value = interpolate_density(w.radius);
        end else begin
            if (!prof_loading) begin
                prof_loading  = 1'b1;
                prof_count    = 0;
                prof_ready    = 1'b0;
                prof_overflow = 1'b0;
            end
            if (prof_count < TABLE_DEPTH) begin
                prof_radius[prof_count]  = w.radius;
                prof_density[prof_count] = w.density;
                prof_count++;
            end else begin
                prof_overflow = 1'b1;
            end
            if (prof_overflow) res.status = ST_OVERFLOW;
            if (w.final_entry) begin
                prof_loading = 1'b0;
                if (!prof_overflow) begin
                    if (!profile_is_valid()) begin
                        res.status = ST_INVALID;
                    end else begin
                        normalise_profile();
                        prof_ready = 1'b1;
                    end
                end
            end
        end
        result_queue.insert(result_queue.size(), res);
    endtask

    function automatic t_item make_word(logic f, logic [23:0] r, logic [31:0] d, logic fin);
        t_item w;
        w.func        = f;
        w.radius      = r;
        w.density     = d;
        w.final_entry = fin;
        return w;
    endfunction

    // A well-formed load of n entries: zero first, then rising radii with random steps.
    task automatic queue_good_load(int unsigned n, logic [31:0] dmax);
        logic [23:0] r;
        int unsigned step_max;
        r = 24'd0;
        step_max = 24'hFF_FFFF / n;
        for (int unsigned k = 0; k < n; k++) begin
            if (k > 0) r = r + 24'($urandom_range(step_max, 1));
            queue_word(make_word(FUNC_LOAD, r, 32'($urandom_range(dmax, 0)), k == n - 1));
        end
    endtask

    task automatic queue_query(logic [23:0] r);
        queue_word(make_word(FUNC_QUERY, r, $urandom, 1'($urandom_range(1, 0))));
    endtask

    function automatic logic [31:0] random_density();
        case ($urandom_range(3, 0))
            0: return 32'hFFFF_FFFF;
            1: return 32'($urandom_range(32'h0004_0000, 0));
            default: return $urandom;
        endcase
    endfunction

    // Driver: on each falling edge either offers the next pending word or idles.
    // The start line is only changed at this one place, once per step.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else if (start && busy) begin
            // The word is held until the block takes it.
        end else begin
            if (start) begin
                void'(word_queue.pop_front());
            end
            if (word_queue.size() > 0 && !hold_sender
                && (quiet_mode || $urandom_range(99, 0) >= 25)) begin
                start  <= 1'b1;
                i_item <= word_queue[0];
            end else begin
                start  <= 1'b0;
            end
        end
    end

    // The model runs at the rising edge at which the block accepts a word.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            predict_profile_word(i_item);
            words_sent++;
            if (i_item.func == FUNC_QUERY) queries_sent++;
        end
    end

    // Monitor: every strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_strobe) begin
            results_seen++;
            if (result_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: value %h status %0d",
                             o_result.value, o_result.status);
            end else begin
                want = result_queue.pop_front();
                if (o_result.value !== want.value || o_result.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected value %h status %0d, got value %h status %0d",
                                 want.value, want.status, o_result.value, o_result.status);
                end
            end
        end
    end

    // Writes the power register while the block is idle, and mirrors it in the model.
    task automatic write_power(logic [31:0] p);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= p;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        power_setting = p;
        power_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued word is accepted and every result has come back,
    // then lets the block settle in case it is still finishing internally.
    task automatic drain_all();
        while (word_queue.size() > 0 || start || result_queue.size() > 0 || busy)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] power_choices [5];
        int unsigned n;
        power_choices = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001,
                          32'h0100_0000};
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        quiet_mode    = 1'b0;
        hold_sender   = 1'b0;
        power_setting = TARGET_POWER_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: query with no table, invalid loads, a minimal valid load,
        // exact hits, zero radius, the last radius and extreme fields.
        queue_query(24'hFF_FFFF);
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'hFFFF_FFFF, 1'b1));
        queue_word(make_word(FUNC_LOAD, 24'd5, 32'd1, 1'b0));
        queue_word(make_word(FUNC_LOAD, 24'd9, 32'd1, 1'b1));
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'd7, 1'b0));
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'd7, 1'b1));
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'd0, 1'b0));
        queue_word(make_word(FUNC_LOAD, 24'hFF_FFFF, 32'd0, 1'b1));
        queue_query(24'd1);
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'hFFFF_FFFF, 1'b0));
        queue_word(make_word(FUNC_LOAD, 24'h01_0000, 32'h8000_0000, 1'b0));
        queue_word(make_word(FUNC_LOAD, 24'hFF_FFFF, 32'd0, 1'b1));
        queue_query(24'd0);
        queue_query(24'h01_0000);
        queue_query(24'h00_8000);
        queue_query(24'hFF_FFFF);
        queue_query(24'hFF_FFFE);
        queue_word(make_word(FUNC_LOAD, 24'd0, 32'd3, 1'b0));
        queue_query(24'd4);
        queue_word(make_word(FUNC_LOAD, 24'd4, 32'd3, 1'b1));
        queue_query(24'd2);
        drain_all();

        // Overflow: one load that runs past the end of the table, then a query.
        for (int unsigned k = 0; k < TABLE_DEPTH + 2; k++)
            queue_word(make_word(FUNC_LOAD, 24'(k * 16), $urandom, k == TABLE_DEPTH + 1));
        queue_query(24'd100);
        // A full-depth valid load uses every table entry once.
        for (int unsigned k = 0; k < TABLE_DEPTH; k++)
            queue_word(make_word(FUNC_LOAD, 24'(k * 65000), random_density(),
                                 k == TABLE_DEPTH - 1));
        for (int unsigned k = 0; k < 6; k++) queue_query(24'($urandom));
        drain_all();

        // Random phases, each under one power setting. The sender is held back
        // once per phase until everything has come back.
        for (int unsigned ph = 0; ph < 7; ph++) begin
            write_power(ph < 5 ? power_choices[ph] : $urandom);
            quiet_mode = (ph == 3);
            for (int unsigned b = 0; b < 4; b++) begin
                case ($urandom_range(9, 0))
                    0: begin
                        // A broken load: random radii and a random length.
                        n = $urandom_range(4, 1);
                        for (int unsigned k = 0; k < n; k++)
                            queue_word(make_word(FUNC_LOAD, 24'($urandom),
                                                 $urandom, k == n - 1));
                    end
                    1: queue_good_load($urandom_range(40, 2), random_density());
                    default: queue_good_load($urandom_range(8, 2), random_density());
                endcase
                n = $urandom_range(14, 6);
                for (int unsigned k = 0; k < n; k++) queue_query(24'($urandom));
            end
            while (word_queue.size() > 20) @(posedge i_clk);
            hold_sender = 1'b1;
            while (start || busy || result_queue.size() > 0) @(posedge i_clk);
            hold_sender = 1'b0;
            drain_all();
        end

        $display("Covered %0d words (%0d queries) with %0d results checked and %0d power writes,",
                 words_sent, queries_sent, results_seen, power_writes);
        $display("including overflow, invalid tables, full-depth tables and extreme power.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: fires far beyond the end of the slowest correct run.
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
